// File: rtl/core/base64_stream_decoder_unit_defines.svh
// Assertion macros for the base64 stream decoder RTL.
// Included by the top level; expects clk and rst_n in the including scope.
`ifndef BASE64_STREAM_DECODER_UNIT_DEFINES_SVH
`define BASE64_STREAM_DECODER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checked only outside reset.
`define B64SD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define B64SD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define B64SD_ASSERT(lbl, prop, msg)
`define B64SD_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// File: rtl/core/b64sd_pkg.sv
// Shared types, constants and the character decode function of the
// base64 stream decoder. No dependencies.
package b64sd_pkg;

  localparam int unsigned RES_FIFO_DEPTH = 8;
  localparam int unsigned MAX_RESULTS    = 3;

  localparam logic [5:0] SEXTET_PLUS  = 6'd62;
  localparam logic [5:0] SEXTET_SLASH = 6'd63;
  localparam logic [5:0] LOWER_BASE   = 6'd26;
  localparam logic [5:0] DIGIT_BASE   = 6'd52;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       run_last;
    logic       decode_error;
    logic       message_done;
  } result_t;

  typedef struct packed {
    logic       bad;
    logic [5:0] sextet;
  } sextet_t;

  // Maps one character code to its sextet; anything outside the alphabet
  // (padding included) comes back flagged as bad.
  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t    r;
    logic [7:0] d;
    r.bad    = 1'b0;
    r.sextet = '0;
    if (c >= "A" && c <= "Z") begin
      d        = c - 8'("A");
      r.sextet = d[5:0];
    end else if (c >= "a" && c <= "z") begin
      d        = c - 8'("a");
      r.sextet = d[5:0] + LOWER_BASE;
    end else if (c >= "0" && c <= "9") begin
      d        = c - 8'("0");
      r.sextet = d[5:0] + DIGIT_BASE;
    end else if (c == "+") begin
      r.sextet = SEXTET_PLUS;
    end else if (c == "/") begin
      r.sextet = SEXTET_SLASH;
    end else begin
      r.bad = 1'b1;
    end
    return r;
  endfunction

endpackage

// File: rtl/core/base64_stream_decoder_unit.sv
// Top level of the base64 stream decoder: character decode, group state and
// a small result queue. Depends on b64sd_pkg and the defines header.
//
//   Port group   Dir   Payload                                          Handshake
//   in_*         in    char_code[7:0], last_char                        in_valid / in_ready
//   out_*        out   data_byte[7:0], run_last, decode_error,          out_valid / out_ready
//                      message_done
//
// One character is taken per cycle; its zero to three result bytes are
// written into the queue in the same cycle and leave one per cycle while out_ready is high.
// The queue throttles input: in_ready is high while it has room for three
// results, so full groups run at one character per cycle while out_ready is high.
// Synchronous active-low reset empties the queue and clears the group state.
`include "base64_stream_decoder_unit_defines.svh"

module base64_stream_decoder_unit #(
  parameter int unsigned RES_DEPTH = b64sd_pkg::RES_FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_code,
  input  logic       in_last_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_data_byte,
  output logic       out_run_last,
  output logic       out_decode_error,
  output logic       out_message_done
);
  import b64sd_pkg::*;

  localparam int unsigned PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned CNT_W = $clog2(RES_DEPTH + 1);

  // Group state
  logic [1:0]  grp_pos_r, grp_pos_nxt;
  logic [17:0] acc_r, acc_nxt;
  logic        err_seen_r, err_seen_nxt;

  // Result queue
  result_t            res_mem_r [RES_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [PTR_W:0]     wr_sum [MAX_RESULTS+1];
  logic [PTR_W-1:0]   wr_idx [MAX_RESULTS+1];

  result_t    res [MAX_RESULTS];
  logic [1:0] push_n;
  logic       in_xfer, out_xfer;
  sextet_t    sx;
  logic [23:0] v;
  logic       err_now;

  assign in_ready = (cnt_r <= CNT_W'(RES_DEPTH - MAX_RESULTS));
  assign in_xfer  = in_valid & in_ready;
  assign out_valid = (cnt_r != '0);
  assign out_xfer  = out_valid & out_ready;

  assign sx      = sextet_of(in_char_code);
  assign err_now = err_seen_r | sx.bad;
  assign v       = {acc_r, sx.sextet};

  always_comb begin
    grp_pos_nxt  = grp_pos_r;
    acc_nxt      = acc_r;
    err_seen_nxt = err_seen_r;
    push_n       = 2'd0;
    for (int k = 0; k < MAX_RESULTS; k++) begin
      res[k] = '0;
    end
    if (in_xfer) begin
      if (err_now || (in_last_char && grp_pos_r == 2'd0)) begin
        if (in_last_char) begin
          res[0].run_last     = 1'b1;
          res[0].decode_error = 1'b1;
          res[0].message_done = 1'b1;
          push_n       = 2'd1;
          grp_pos_nxt  = 2'd0;
          acc_nxt      = '0;
          err_seen_nxt = 1'b0;
        end else begin
          err_seen_nxt = 1'b1;
        end
      end else if (grp_pos_r == 2'd3) begin
        res[0].data_byte    = v[23:16];
        res[1].data_byte    = v[15:8];
        res[2].data_byte    = v[7:0];
        res[2].run_last     = 1'b1;
        res[2].message_done = in_last_char;
        push_n      = 2'd3;
        grp_pos_nxt = 2'd0;
        acc_nxt     = '0;
      end else if (in_last_char) begin
        // Tail of two or three characters; spare low bits are dropped.
        if (grp_pos_r == 2'd1) begin
          res[0].data_byte    = v[11:4];
          res[0].run_last     = 1'b1;
          res[0].message_done = 1'b1;
          push_n = 2'd1;
        end else begin
          res[0].data_byte    = v[17:10];
          res[1].data_byte    = v[9:2];
          res[1].run_last     = 1'b1;
          res[1].message_done = 1'b1;
          push_n = 2'd2;
        end
        grp_pos_nxt = 2'd0;
        acc_nxt     = '0;
      end else begin
        acc_nxt     = v[17:0];
        grp_pos_nxt = grp_pos_r + 2'd1;
      end
    end
  end

  // Queue slots for the results of this transfer, wrapping at the depth.
  always_comb begin
    for (int k = 0; k <= MAX_RESULTS; k++) begin
      wr_sum[k] = {1'b0, wr_ptr_r} + (PTR_W+1)'(k);
      if (wr_sum[k] >= (PTR_W+1)'(RES_DEPTH)) begin
        wr_sum[k] = wr_sum[k] - (PTR_W+1)'(RES_DEPTH);
      end
      wr_idx[k] = wr_sum[k][PTR_W-1:0];
    end
  end

  always_comb begin
    wr_ptr_nxt = wr_idx[push_n];
    rd_ptr_nxt = rd_ptr_r;
    if (out_xfer) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(RES_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    cnt_nxt = cnt_r + CNT_W'(push_n) - CNT_W'(out_xfer);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_pos_r  <= '0;
      acc_r      <= '0;
      err_seen_r <= 1'b0;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      cnt_r      <= '0;
    end else begin
      grp_pos_r  <= grp_pos_nxt;
      acc_r      <= acc_nxt;
      err_seen_r <= err_seen_nxt;
      wr_ptr_r   <= wr_ptr_nxt;
      rd_ptr_r   <= rd_ptr_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RESULTS; k++) begin
      if (2'(k) < push_n) begin
        res_mem_r[wr_idx[k]] <= res[k];
      end
    end
  end

  assign out_data_byte    = res_mem_r[rd_ptr_r].data_byte;
  assign out_run_last     = res_mem_r[rd_ptr_r].run_last;
  assign out_decode_error = res_mem_r[rd_ptr_r].decode_error;
  assign out_message_done = res_mem_r[rd_ptr_r].message_done;

  `B64SD_ASSERT(a_err_result_form,
    (out_valid && out_decode_error) |->
      (out_run_last && out_message_done && out_data_byte == 8'd0),
    "error result must be a final zero byte")
  `B64SD_ASSERT(a_state_clear_after_last,
    (in_xfer && in_last_char) |=> (grp_pos_r == 2'd0 && acc_r == 18'd0 && !err_seen_r),
    "group state not cleared after last character")
  `B64SD_ASSERT(a_cnt_tracks,
    out_xfer |=> (cnt_r == $past(cnt_r) + CNT_W'($past(push_n)) - CNT_W'(1)),
    "queue count out of step")
  `B64SD_ASSERT(a_cnt_bound, cnt_r <= CNT_W'(RES_DEPTH), "queue count beyond depth")
  `B64SD_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> (cnt_r == CNT_W'(0)),
    "queue not empty after reset")

endmodule

// File: bench/base64_stream_decoder_unit_tb.sv
// Self-checking testbench for base64_stream_decoder_unit: directed messages, then random
// well-formed and broken messages, with random stalls on both handshakes.
// Depends on b64sd_pkg and the decoder RTL.
module base64_stream_decoder_unit_tb;
  import b64sd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned ITEM_TARGET = 226;

  // Predicts the decoded bytes of each message and checks them in order.
  class b64_byte_scoreboard;
    result_t     expected_bytes[$];
    logic [1:0]  held_count;
    logic [17:0] held_bits;
    bit          msg_bad;
    int unsigned fail_count;

    function new();
      fail_count = 0;
      clear_message();
    endfunction

    function void clear_message();
      held_count = '0;
      held_bits  = '0;
      msg_bad    = 1'b0;
    endfunction

    function bit decode_char(input logic [7:0] c, output logic [5:0] sx);
      sx = '0;
      if (c >= "A" && c <= "Z") begin
        sx = 6'(c - "A");
      end else if (c >= "a" && c <= "z") begin
        sx = 6'(c - "a") + LOWER_BASE;
      end else if (c >= "0" && c <= "9") begin
        sx = 6'(c - "0") + DIGIT_BASE;
      end else if (c == "+") begin
        sx = SEXTET_PLUS;
      end else if (c == "/") begin
        sx = SEXTET_SLASH;
      end else begin
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void push(logic [7:0] b, logic rl, logic err, logic done);
      result_t r;
      r.data_byte    = b;
      r.run_last     = rl;
      r.decode_error = err;
      r.message_done = done;
      expected_bytes.push_back(r);
    endfunction

    function void note_char(logic [7:0] c, logic is_last);
      logic [5:0]  sx;
      logic [23:0] v;
      if (!decode_char(c, sx)) msg_bad = 1'b1;
      // A bad character anywhere, or a message ending on a group boundary with
      // a single leftover, collapses to one error transfer at the end.
      if (msg_bad || (is_last && held_count == 2'd0)) begin
        if (is_last) begin
          push(8'h00, 1'b1, 1'b1, 1'b1);
          clear_message();
        end
        return;
      end
      v = {held_bits, sx};
      if (held_count == 2'd3) begin
        push(v[23:16], 1'b0, 1'b0, 1'b0);
        push(v[15:8], 1'b0, 1'b0, 1'b0);
        push(v[7:0], 1'b1, 1'b0, is_last);
        held_count = '0;
        held_bits  = '0;
      end else if (is_last) begin
        if (held_count == 2'd1) begin
          push(v[11:4], 1'b1, 1'b0, 1'b1);
        end else begin
          push(v[17:10], 1'b0, 1'b0, 1'b0);
          push(v[9:2], 1'b1, 1'b0, 1'b1);
        end
      end else begin
        held_bits  = v[17:0];
        held_count = held_count + 2'd1;
      end
      if (is_last) clear_message();
    endfunction

    function void check_byte(result_t got);
      result_t exp_r;
      if (expected_bytes.size() == 0) begin
        $error("unexpected result transfer: data_byte=%02h", got.data_byte);
        fail_count++;
        return;
      end
      exp_r = expected_bytes.pop_front();
      if (got.data_byte !== exp_r.data_byte) begin
        $error("data_byte: expected %02h, got %02h", exp_r.data_byte, got.data_byte);
        fail_count++;
      end
      if (got.run_last !== exp_r.run_last) begin
        $error("run_last: expected %0b, got %0b", exp_r.run_last, got.run_last);
        fail_count++;
      end
      if (got.decode_error !== exp_r.decode_error) begin
        $error("decode_error: expected %0b, got %0b", exp_r.decode_error, got.decode_error);
        fail_count++;
      end
      if (got.message_done !== exp_r.message_done) begin
        $error("message_done: expected %0b, got %0b", exp_r.message_done, got.message_done);
        fail_count++;
      end
    endfunction

    function int outstanding();
      return expected_bytes.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_char_code = 8'h00;
  logic       in_last_char = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_data_byte;
  logic       out_run_last;
  logic       out_decode_error;
  logic       out_message_done;

  b64_byte_scoreboard sb = new();
  int unsigned cycle_count = 0;
  int unsigned item_count = 0;
  bit steady = 1'b0;

  base64_stream_decoder_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_code     (in_char_code),
    .in_last_char     (in_last_char),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data_byte    (out_data_byte),
    .out_run_last     (out_run_last),
    .out_decode_error (out_decode_error),
    .out_message_done (out_message_done)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Both transfers are seen in one process so a result can never be checked
  // before the character that caused it has been noted.
  always @(posedge clk) begin
    result_t got;
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("base64_stream_decoder_unit verification failed");
      $finish;
    end
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_char(in_char_code, in_last_char);
      if (out_valid && out_ready) begin
        got.data_byte    = out_data_byte;
        got.run_last     = out_run_last;
        got.decode_error = out_decode_error;
        got.message_done = out_message_done;
        sb.check_byte(got);
      end
    end
  end

  function automatic int draw_gap();
    return steady ? 0 : $urandom_range(0, 3);
  endfunction

  function automatic logic [7:0] char_of_sextet(int unsigned idx);
    if (idx < 26) return 8'("A" + idx);
    if (idx < 52) return 8'("a" + idx - 26);
    if (idx < 62) return 8'("0" + idx - 52);
    if (idx == 62) return "+";
    return "/";
  endfunction

  task automatic send_char(input logic [7:0] c, input logic is_last);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= c;
    in_last_char <= is_last;
    do @(posedge clk); while (!(in_valid && in_ready));
    item_count++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic send_random_message();
    int len;
    int bad_at;
    logic [7:0] c;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
    bad_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, len - 1) : -1;
    for (int i = 0; i < len; i++) begin
      if (i == bad_at) c = $urandom_range(0, 1) ? 8'("=") : 8'($urandom_range(0, 255));
      else c = char_of_sextet($urandom_range(0, 63));
      send_char(c, i == len - 1);
    end
  endtask

  task automatic drain_results();
    int stall;
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    fork
      drain_results();
    join_none

    // Full groups with every symbol class, then a two-byte tail decoding to FF and F0.
    send_text("TWFu/+9z");
    send_text("//A");
    // One-byte tail whose unused low bits are not zero.
    send_text("TR");
    // A single leftover character at the end is an error.
    send_text("T");
    // Padding and a high code mid-message poison the rest of the message.
    send_char("T", 1'b0);
    send_char("=", 1'b0);
    send_char(8'hFF, 1'b0);
    send_char("b", 1'b1);
    // An invalid character as the last one.
    send_char("A", 1'b0);
    send_char(8'h00, 1'b1);

    while (item_count < ITEM_TARGET) begin
      steady = ($urandom_range(0, 5) == 0);
      send_random_message();
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.outstanding() != 0) begin
      $error("%0d expected transfers never arrived", sb.outstanding());
      sb.fail_count++;
    end
    if (sb.fail_count == 0) begin
      $display("base64_stream_decoder_unit verification clean");
    end else begin
      $display("base64_stream_decoder_unit verification failed");
    end
    $finish;
  end
endmodule
